// File: sv/tlru_pkg.sv
// shared types and constants for the tlb lookup with lru replacement
package tlru_pkg;

    localparam int ENTRIES     = 5;
    localparam int OFFSET_BITS = 12;
    localparam int ADDR_W      = 32;
    localparam int TAG_W       = ADDR_W - OFFSET_BITS;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W      = $clog2(ENTRIES + 1);
    localparam int PAGE_OUT_W  = 20;
    localparam int OFFS_OUT_W  = 12;
    localparam int SLOT_OUT_W  = 3;

    localparam logic [ADDR_W-1:0] OFFSET_MASK = ADDR_W'((64'd1 << OFFSET_BITS) - 64'd1);
    localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(ENTRIES - 1);
    localparam logic [RANK_W-1:0] RANK_ALL    = RANK_W'(ENTRIES);

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic              empty;
        logic [IDX_W-1:0]  empty_idx;
        logic              victim;
        logic [IDX_W-1:0]  victim_idx;
    } t_scan;

    typedef struct packed {
        logic              en;
        logic              fill;
        logic [IDX_W-1:0]  sel_idx;
        logic [RANK_W-1:0] thr;
        logic [TAG_W-1:0]  tag;
    } t_upd;

endpackage

// File: sv/tlru_cell.sv
// one tlb slot: valid bit, page tag and age rank, with its link in the scan chain
module tlru_cell
    import tlru_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [TAG_W-1:0] i_tag,
    input  t_scan            i_scan,
    output t_scan            o_scan,
    input  t_upd             i_upd
);

    logic              r_valid;
    logic [TAG_W-1:0]  r_tag;
    logic [RANK_W-1:0] r_rank;
    logic              w_match;
    logic              w_oldest;

    assign w_match  = r_valid && (r_tag == i_tag);
    assign w_oldest = (r_rank == RANK_OLDEST);

    always_comb begin
        o_scan = i_scan;
        if (!i_scan.hit && w_match) begin
            o_scan.hit      = 1'b1;
            o_scan.hit_idx  = i_idx;
            o_scan.hit_rank = r_rank;
        end
        if (!i_scan.empty && !r_valid) begin
            o_scan.empty     = 1'b1;
            o_scan.empty_idx = i_idx;
        end
        if (!i_scan.victim && w_oldest) begin
            o_scan.victim     = 1'b1;
            o_scan.victim_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.en) begin
            if (i_upd.sel_idx == i_idx) begin
                r_rank <= '0;
                if (i_upd.fill) begin
                    r_valid <= 1'b1;
                end
            end else if (r_valid && (r_rank < i_upd.thr)) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.fill && (i_upd.sel_idx == i_idx)) begin
            r_tag <= i_upd.tag;
        end
    end

endmodule

// File: sv/tlb_lookup_lru_replace_unit.sv
// top level: fully associative tlb with lru replacement built as a row of slot cells
// result beat: registered, and valid in the cycle after its accepted address beat
// throughput: one address per cycle while the input is not stalled, set by the combinational scan along the cell row
// input stall rises only while a result is held and the output is stalled
// reset: synchronous active low; all slots empty, ranks zero, no result pending
module tlb_lookup_lru_replace_unit
    import tlru_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ADDR_W-1:0]     i_virtual_address,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_hit,
    output logic                  o_replaced,
    output logic [SLOT_OUT_W-1:0] o_slot_index,
    output logic [PAGE_OUT_W-1:0] o_page_number,
    output logic [OFFS_OUT_W-1:0] o_page_offset
);

    t_scan            w_scan [0:ENTRIES];
    t_upd             w_upd;
    logic [TAG_W-1:0] w_tag;
    logic             w_accept;
    logic [IDX_W-1:0] w_sel;
    logic             w_replaced;

    logic                  r_out_valid;
    logic                  r_hit;
    logic                  r_replaced;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic [PAGE_OUT_W-1:0] r_page;
    logic [OFFS_OUT_W-1:0] r_offs;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_tag      = TAG_W'(i_virtual_address >> OFFSET_BITS);

    assign w_scan[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        tlru_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_tag   (w_tag),
            .i_scan  (w_scan[g]),
            .o_scan  (w_scan[g+1]),
            .i_upd   (w_upd)
        );
    end

    always_comb begin
        w_replaced = 1'b0;
        if (w_scan[ENTRIES].hit) begin
            w_sel     = w_scan[ENTRIES].hit_idx;
            w_upd.thr = w_scan[ENTRIES].hit_rank;
        end else if (w_scan[ENTRIES].empty) begin
            w_sel     = w_scan[ENTRIES].empty_idx;
            w_upd.thr = RANK_ALL;
        end else begin
            w_sel      = w_scan[ENTRIES].victim_idx;
            w_upd.thr  = RANK_OLDEST;
            w_replaced = 1'b1;
        end
        w_upd.en      = w_accept;
        w_upd.fill    = !w_scan[ENTRIES].hit;
        w_upd.sel_idx = w_sel;
        w_upd.tag     = w_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit      <= w_scan[ENTRIES].hit;
            r_replaced <= w_replaced;
            r_slot     <= SLOT_OUT_W'(w_sel);
            r_page     <= PAGE_OUT_W'(i_virtual_address >> OFFSET_BITS);
            r_offs     <= OFFS_OUT_W'(i_virtual_address & OFFSET_MASK);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_replaced    = r_replaced;
    assign o_slot_index  = r_slot;
    assign o_page_number = r_page;
    assign o_page_offset = r_offs;

endmodule

// File: sv/tlru_checker.sv
// port-level checks for the tlb lookup unit and the bind that attaches them
module tlru_checker
    import tlru_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  logic [ADDR_W-1:0]     i_virtual_address,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  logic                  o_hit,
    input  logic                  o_replaced,
    input  logic [SLOT_OUT_W-1:0] o_slot_index,
    input  logic [PAGE_OUT_W-1:0] o_page_number,
    input  logic [OFFS_OUT_W-1:0] o_page_offset
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_page_number) && $stable(o_slot_index)
             && $stable(o_hit) && $stable(o_replaced) && $stable(o_page_offset)))
        else $error("stalled result beat changed");

    // accepted address gives a result beat next cycle with its page and offset
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=>
            (o_out_valid
             && o_page_number == PAGE_OUT_W'($past(i_virtual_address) >> OFFSET_BITS)
             && o_page_offset == OFFS_OUT_W'($past(i_virtual_address) & OFFSET_MASK)))
        else $error("result beat missing or fields wrong");

    // a hit never evicts
    a_hit_no_replace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_replaced))
        else $error("hit reported with replacement");

    // slot index stays inside the table
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((ENTRIES > 8) || (int'(o_slot_index) < ENTRIES)))
        else $error("slot index out of range");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result beat valid after reset");

endmodule

bind tlb_lookup_lru_replace_unit tlru_checker u_tlru_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_virtual_address (i_virtual_address),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_hit             (o_hit),
    .o_replaced        (o_replaced),
    .o_slot_index      (o_slot_index),
    .o_page_number     (o_page_number),
    .o_page_offset     (o_page_offset)
);
